### hdl/pes_pkg.sv
// Package for the polyline equal-spacing resampler.
// Holds shared constants, the front-to-back queue entry type, FSM enums and an abs_diff helper.
// No dependencies.
package pes_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned DiffW      = CoordW + 1;
  localparam int unsigned LenW       = 34;
  localparam int unsigned SpacingW   = 31;
  localparam int unsigned MaxRun     = 64;
  localparam int unsigned CntW       = $clog2(MaxRun + 1);
  localparam int unsigned QDepth     = 2;
  localparam int unsigned SqrtSteps  = 34;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned UnitFrac   = 28;
  localparam logic [SpacingW-1:0] SpacingRst = 31'd25600;

  typedef struct packed {
    logic               first;
    logic [CoordW-1:0]  bx;
    logic [CoordW-1:0]  by;
    logic [CoordW-1:0]  bz;
    logic [DiffW-1:0]   dx;
    logic [DiffW-1:0]   dy;
    logic [DiffW-1:0]   dz;
    logic [LenW-1:0]    len;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_SQRT,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIVN,
    B_DIVS,
    B_DIVU,
    B_MUL,
    B_OUT
  } back_state_e;

  function automatic logic [DiffW-1:0] abs_diff(input logic [DiffW-1:0] v);
    abs_diff = v[DiffW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

### hdl/polyline_equal_spacing_resampler.sv
// Top level of the polyline equal-spacing resampler.
// Depends on pes_pkg, pes_front, pes_queue, pes_back (and pes_div below it).
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | tdata x,y,z; tuser first_vertex
//  m       | out | m_tvalid/m_tready  | tdata x,y,z; tlast last_of_run; tuser overflow
//  cfg     | in  | cfg_we             | cfg_wdata spacing
//
// A first vertex goes from transfer straight to push in the front, and the back sends it out
// directly. A segment vertex passes the front through transfer, three squares, a 34-step root
// and push, then in the back a count divide and three direction divides (only the count divide
// when no point is reached), plus a multiply and an output step for each emitted point.
// Reset clears all control state and sets spacing to 100.0.
// Output stalls hold the back end; the queue lets the front keep working meanwhile.
module polyline_equal_spacing_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [95:0] s_tdata_i,   // point_x, point_y, point_z
  input  logic        s_tuser_i,   // first_vertex
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [95:0] m_tdata_o,   // out_x, out_y, out_z
  output logic        m_tlast_o,   // last_of_run
  output logic        m_tuser_o,   // overflow
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  logic [30:0]     spacing_q;
  logic            q_push, q_full, q_pop, q_empty;
  pes_pkg::entry_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spacing_q <= pes_pkg::SpacingRst;
    else if (cfg_we_i) spacing_q <= cfg_wdata_i;
  end

  pes_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_tvalid_i),
    .ready_o(s_tready_o),
    .first_i(s_tuser_i),
    .px_i   (s_tdata_i[31:0]),
    .py_i   (s_tdata_i[63:32]),
    .pz_i   (s_tdata_i[95:64]),
    .push_o (q_push),
    .entry_o(q_wdata),
    .full_i (q_full)
  );

  pes_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  pes_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .spacing_i(spacing_q),
    .empty_i  (q_empty),
    .head_i   (q_rdata),
    .pop_o    (q_pop),
    .m_valid_o(m_tvalid_o),
    .m_ready_i(m_tready_i),
    .m_data_o (m_tdata_o),
    .m_last_o (m_tlast_o),
    .m_ovf_o  (m_tuser_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue pop while empty");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o) else $error("front took two items back to back");

endmodule

### hdl/pes_div.sv
// Sequential restoring divider, one quotient bit per cycle.
// Depends on pes_pkg.
module pes_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [33:0] rem_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [33:0] rem_q, dvs_q;
  logic [34:0] rs;
  logic        ge;

  assign rs = {rem_q, num_q[63]};
  assign ge = rs >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'(pes_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], ge};
      rem_q <= ge ? 34'(rs - {1'b0, dvs_q}) : rs[33:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

### hdl/pes_front.sv
// Front end: accepts vertices, classifies first/segment, finds segment length.
// Depends on pes_pkg.
module pes_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 first_i,
  input  logic [31:0]          px_i,
  input  logic [31:0]          py_i,
  input  logic [31:0]          pz_i,
  output logic                 push_o,
  output pes_pkg::entry_t      entry_o,
  input  logic                 full_i
);

  pes_pkg::front_state_e state_q, state_d;
  pes_pkg::entry_t       ent_q;
  logic [31:0] prev_x_q, prev_y_q, prev_z_q;
  logic        have_prev_q;
  logic [1:0]  idx_q;
  logic [65:0] acc_q;
  logic [67:0] op_q;
  logic [33:0] root_q;
  logic [34:0] rem_q;
  logic [5:0]  step_q;

  logic        take, is_first;
  logic [32:0] dsel, dmag;
  logic [65:0] sq, acc_nx;
  logic [36:0] rem_s, trial;
  logic        fit;
  logic [33:0] root_nx;

  assign take     = (state_q == pes_pkg::F_IDLE) && valid_i;
  assign is_first = first_i || !have_prev_q;

  always_comb begin
    unique case (idx_q)
      2'd0:    dsel = ent_q.dx;
      2'd1:    dsel = ent_q.dy;
      default: dsel = ent_q.dz;
    endcase
  end
  assign dmag   = pes_pkg::abs_diff(dsel);
  assign sq     = dmag * dmag;
  assign acc_nx = acc_q + sq;

  assign rem_s   = {rem_q, op_q[67:66]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign fit     = rem_s >= trial;
  assign root_nx = {root_q[32:0], fit};

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    unique case (state_q)
      pes_pkg::F_IDLE: if (valid_i) state_d = is_first ? pes_pkg::F_PUSH : pes_pkg::F_SQ;
      pes_pkg::F_SQ:   if (idx_q == 2'd2) state_d = pes_pkg::F_SQRT;
      pes_pkg::F_SQRT: if (step_q == 6'(pes_pkg::SqrtSteps - 1)) state_d = pes_pkg::F_PUSH;
      pes_pkg::F_PUSH: begin
        push_o = !full_i;
        if (!full_i) state_d = pes_pkg::F_IDLE;
      end
      default:         state_d = pes_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pes_pkg::F_IDLE;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        have_prev_q <= 1'b1;
        prev_x_q    <= px_i;
        prev_y_q    <= py_i;
        prev_z_q    <= pz_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pes_pkg::F_IDLE: begin
        ent_q.first <= is_first;
        ent_q.bx    <= is_first ? px_i : prev_x_q;
        ent_q.by    <= is_first ? py_i : prev_y_q;
        ent_q.bz    <= is_first ? pz_i : prev_z_q;
        ent_q.dx    <= {px_i[31], px_i} - {prev_x_q[31], prev_x_q};
        ent_q.dy    <= {py_i[31], py_i} - {prev_y_q[31], prev_y_q};
        ent_q.dz    <= {pz_i[31], pz_i} - {prev_z_q[31], prev_z_q};
        ent_q.len   <= '0;
        idx_q       <= '0;
        acc_q       <= '0;
      end
      pes_pkg::F_SQ: begin
        acc_q <= acc_nx;
        idx_q <= idx_q + 1'b1;
        op_q  <= {2'b00, acc_nx};
        root_q <= '0;
        rem_q  <= '0;
        step_q <= '0;
      end
      pes_pkg::F_SQRT: begin
        op_q   <= {op_q[65:0], 2'b00};
        rem_q  <= fit ? 35'(rem_s - trial) : rem_s[34:0];
        root_q <= root_nx;
        step_q <= step_q + 1'b1;
        if (step_q == 6'(pes_pkg::SqrtSteps - 1)) ent_q.len <= root_nx;
      end
      default: ;
    endcase
  end

  assign ready_o = (state_q == pes_pkg::F_IDLE);
  assign entry_o = ent_q;

endmodule

### hdl/pes_queue.sv
// Two-entry queue between front and back ends.
// Depends on pes_pkg.
module pes_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pes_pkg::entry_t  wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output pes_pkg::entry_t  rdata_o,
  output logic             empty_o
);

  pes_pkg::entry_t mem_q [pes_pkg::QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign full_o  = (cnt_q == 2'(pes_pkg::QDepth));
  assign empty_o = (cnt_q == 2'd0);

endmodule

### hdl/pes_back.sv
// Back end: leftover bookkeeping, point count, unit direction and point emission.
// Depends on pes_pkg and pes_div.
module pes_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [30:0]      spacing_i,
  input  logic             empty_i,
  input  pes_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [95:0]      m_data_o,
  output logic             m_last_o,
  output logic             m_ovf_o
);

  pes_pkg::back_state_e state_q, state_d;
  pes_pkg::entry_t ent_q;
  logic [30:0] left_q;
  logic [pes_pkg::CntW-1:0] cnt_q, k_q;
  logic        ovf_q;
  logic [39:0] t_q;
  logic [28:0] u_q [3];
  logic [2:0]  us_q;
  logic [1:0]  a_q, ph_q;
  logic [47:0] prod_q, plo_q;
  logic [31:0] res_q [3];
  logic        mv_q, ml_q, mo_q;
  logic [95:0] md_q;

  logic [30:0] dsp;
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [33:0] div_dvs, div_rem;
  logic [32:0] dsel, dmag;
  logic [31:0] bsel;
  logic [37:0] tmag;
  logic [18:0] tpart;
  logic [67:0] full;
  logic [37:0] offmag;
  logic [39:0] off;
  logic [41:0] sum;
  logic [31:0] sat;
  logic        ld, is_last;

  assign dsp = (spacing_i == '0) ? 31'd1 : spacing_i;

  always_comb begin
    unique case (a_q)
      2'd0:    begin dsel = ent_q.dx; bsel = ent_q.bx; end
      2'd1:    begin dsel = ent_q.dy; bsel = ent_q.by; end
      default: begin dsel = ent_q.dz; bsel = ent_q.bz; end
    endcase
  end
  assign dmag = pes_pkg::abs_diff(dsel);

  always_comb begin
    if (state_q == pes_pkg::B_IDLE) begin
      div_num = {29'b0, {4'b0, left_q} + {1'b0, head_i.len}};
      div_dvs = {3'b0, dsp};
    end else begin
      div_num = {3'b0, dmag, 28'b0} + {31'b0, ent_q.len[33:1]};
      div_dvs = ent_q.len;
    end
  end

  pes_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  assign tmag   = t_q[39] ? 38'(~t_q + 1'b1) : t_q[37:0];
  assign tpart  = (ph_q == 2'd0) ? tmag[18:0] : tmag[37:19];
  assign full   = {1'b0, prod_q, 19'b0} + {20'b0, plo_q} + 68'(1 << 27);
  assign offmag = full[65:28];
  assign off    = (us_q[a_q] ^ t_q[39]) ? 40'(~{2'b0, offmag} + 1'b1) : {2'b0, offmag};
  assign sum    = {{10{bsel[31]}}, bsel} + {{2{off[39]}}, off};
  always_comb begin
    if (sum[41:31] == '0 || sum[41:31] == '1) sat = sum[31:0];
    else if (sum[41]) sat = 32'h8000_0000;
    else sat = 32'h7FFF_FFFF;
  end

  assign ld      = !mv_q || m_ready_i;
  assign is_last = ent_q.first || (pes_pkg::CntW'(k_q + 1'b1) == cnt_q);

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      pes_pkg::B_IDLE: if (!empty_i) begin
        pop_o = 1'b1;
        if (head_i.first) state_d = pes_pkg::B_OUT;
        else begin
          div_start = 1'b1;
          state_d   = pes_pkg::B_DIVN;
        end
      end
      pes_pkg::B_DIVN: if (div_done) state_d = (div_quo == '0) ? pes_pkg::B_IDLE : pes_pkg::B_DIVS;
      pes_pkg::B_DIVS: begin
        div_start = 1'b1;
        state_d   = pes_pkg::B_DIVU;
      end
      pes_pkg::B_DIVU: if (div_done) state_d = (a_q == 2'd2) ? pes_pkg::B_MUL : pes_pkg::B_DIVS;
      pes_pkg::B_MUL:  if (ph_q == 2'd2 && a_q == 2'd2) state_d = pes_pkg::B_OUT;
      pes_pkg::B_OUT:  if (ld) state_d = is_last ? pes_pkg::B_IDLE : pes_pkg::B_MUL;
      default:         state_d = pes_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pes_pkg::B_IDLE;
      left_q  <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pes_pkg::B_IDLE && !empty_i && head_i.first) left_q <= '0;
      if (state_q == pes_pkg::B_DIVN && div_done) left_q <= div_rem[30:0];
      if (state_q == pes_pkg::B_OUT && ld) mv_q <= 1'b1;
      else if (m_ready_i) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pes_pkg::B_IDLE: begin
        ent_q <= head_i;
        res_q[0] <= head_i.bx;
        res_q[1] <= head_i.by;
        res_q[2] <= head_i.bz;
        ovf_q <= 1'b0;
      end
      pes_pkg::B_DIVN: if (div_done) begin
        ovf_q <= div_quo > 64'(pes_pkg::MaxRun);
        cnt_q <= (div_quo > 64'(pes_pkg::MaxRun)) ? pes_pkg::CntW'(pes_pkg::MaxRun)
                                                  : div_quo[pes_pkg::CntW-1:0];
        t_q   <= {9'b0, dsp} - {9'b0, left_q};
        k_q   <= '0;
        a_q   <= '0;
      end
      pes_pkg::B_DIVU: if (div_done) begin
        u_q[a_q]  <= (ent_q.len == '0) ? 29'd0 : div_quo[28:0];
        us_q[a_q] <= dsel[32];
        a_q       <= (a_q == 2'd2) ? 2'd0 : a_q + 1'b1;
        ph_q      <= '0;
      end
      pes_pkg::B_MUL: begin
        unique case (ph_q)
          2'd0: begin
            prod_q <= u_q[a_q] * tpart;
            ph_q   <= 2'd1;
          end
          2'd1: begin
            plo_q  <= prod_q;
            prod_q <= u_q[a_q] * tpart;
            ph_q   <= 2'd2;
          end
          default: begin
            res_q[a_q] <= sat;
            ph_q       <= '0;
            a_q        <= (a_q == 2'd2) ? 2'd0 : a_q + 1'b1;
          end
        endcase
      end
      pes_pkg::B_OUT: if (ld) begin
        md_q <= {res_q[2], res_q[1], res_q[0]};
        ml_q <= is_last;
        mo_q <= ovf_q;
        k_q  <= k_q + 1'b1;
        t_q  <= t_q + {9'b0, dsp};
        a_q  <= '0;
        ph_q <= '0;
      end
      default: ;
    endcase
  end

  assign m_valid_o = mv_q;
  assign m_data_o  = md_q;
  assign m_last_o  = ml_q;
  assign m_ovf_o   = mo_q;

endmodule

### test/pes_resample_checker.sv
// Checker for the polyline equal-spacing resampler: watches input, output and config
// transfers, predicts the resampled points and compares them field by field.
// Depends on nothing but the port widths of the block.
module pes_resample_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [95:0] s_tdata_i,   // point_x, point_y, point_z
  input  logic        s_tuser_i,   // first_vertex
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [95:0] m_tdata_i,   // out_x, out_y, out_z
  input  logic        m_tlast_i,   // last_of_run
  input  logic        m_tuser_i,   // overflow
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  output int          err_count_o,
  output int          pending_o,
  output int          delivered_o,
  output int          overflow_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RunCap = 64;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic        ovf;
  } point_t;

  point_t      expected_points[$];
  logic [30:0] spacing;
  longint      prev_x, prev_y, prev_z;
  logic [31:0] leftover;
  logic        have_prev;
  int          mismatches;

  assign err_count_o = mismatches;
  assign pending_o   = expected_points.size();

  function automatic logic [63:0] mag64(input longint v);
    mag64 = (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    clamp32 = v[31:0];
  endfunction

  function automatic longint unit_axis(input longint d, input logic [63:0] len);
    logic [63:0] m;
    if (len == 0) return 0;
    m = ((mag64(d) << 28) + len / 2) / len;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint step_axis(input longint u, input longint t);
    logic [63:0] m;
    m = (mag64(u) * mag64(t) + (64'd1 << 27)) >> 28;
    return ((u < 0) != (t < 0)) ? -longint'(m) : longint'(m);
  endfunction

  task automatic resample_vertex(input logic first, input logic [95:0] pt);
    longint      px, py, pz, dx, dy, dz, ux, uy, uz, t;
    logic [67:0] sq, c;
    logic [63:0] len, d, total, npts;
    int          count;
    point_t      p;
    px = longint'($signed(pt[31:0]));
    py = longint'($signed(pt[63:32]));
    pz = longint'($signed(pt[95:64]));
    if (first || !have_prev) begin
      p.x = pt[31:0]; p.y = pt[63:32]; p.z = pt[95:64]; p.last = 1'b1; p.ovf = 1'b0;
      expected_points.push_back(p);
      leftover  = '0;
      have_prev = 1'b1;
    end else begin
      dx = px - prev_x; dy = py - prev_y; dz = pz - prev_z;
      sq = 68'(mag64(dx)) * 68'(mag64(dx)) + 68'(mag64(dy)) * 68'(mag64(dy))
         + 68'(mag64(dz)) * 68'(mag64(dz));
      len = 0;
      for (int b = 33; b >= 0; b--) begin
        c = 68'(len) | (68'd1 << b);
        if (c * c <= sq) len = c[63:0];
      end
      d     = (spacing == 0) ? 64'd1 : 64'(spacing);
      total = 64'(leftover) + len;
      npts  = total / d;
      count = (npts > RunCap) ? RunCap : int'(npts);
      ux = unit_axis(dx, len); uy = unit_axis(dy, len); uz = unit_axis(dz, len);
      for (int k = 0; k < count; k++) begin
        t = longint'(64'(k + 1) * d) - longint'(64'(leftover));
        p.x    = clamp32(prev_x + step_axis(ux, t));
        p.y    = clamp32(prev_y + step_axis(uy, t));
        p.z    = clamp32(prev_z + step_axis(uz, t));
        p.last = (k == count - 1);
        p.ovf  = (npts > RunCap);
        expected_points.push_back(p);
      end
      leftover = 32'(total % d);
    end
    prev_x = px; prev_y = py; prev_z = pz;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      spacing = 31'd25600;
      prev_x = 0; prev_y = 0; prev_z = 0;
      leftover = '0; have_prev = 1'b0;
      mismatches = 0; delivered_o = 0; overflow_seen_o = 0;
      expected_points.delete();
    end else begin
      if (cfg_we_i) spacing = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) resample_vertex(s_tuser_i, s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        delivered_o++;
        if (m_tuser_i) overflow_seen_o++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected point x=%h y=%h z=%h", $realtime,
                     m_tdata_i[31:0], m_tdata_i[63:32], m_tdata_i[95:64]);
        end else begin
          e = expected_points.pop_front();
          if (e.x !== m_tdata_i[31:0] || e.y !== m_tdata_i[63:32] ||
              e.z !== m_tdata_i[95:64] || e.last !== m_tlast_i || e.ovf !== m_tuser_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: point mismatch exp x=%h y=%h z=%h last=%b ovf=%b", $realtime,
                       e.x, e.y, e.z, e.last, e.ovf);
              $display("    got x=%h y=%h z=%h last=%b ovf=%b", m_tdata_i[31:0],
                       m_tdata_i[63:32], m_tdata_i[95:64], m_tlast_i, m_tuser_i);
            end
          end
        end
      end
    end
  end

endmodule

### test/tb_polyline_equal_spacing_resampler.sv
// Testbench top for the polyline equal-spacing resampler: clock, reset, vertex and
// spacing stimulus, output back-pressure and verdict.
// Depends on polyline_equal_spacing_resampler and pes_resample_checker.
module tb_polyline_equal_spacing_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 1500;

  logic        clk_i, rst_ni;
  logic        s_tvalid_i, s_tready_o, s_tuser_i;
  logic [95:0] s_tdata_i;
  logic        m_tvalid_o, m_tready_i, m_tlast_o, m_tuser_o;
  logic [95:0] m_tdata_o;
  logic        cfg_we_i;
  logic [30:0] cfg_wdata_i;
  int          err_count, pending, delivered, overflow_seen;
  logic        calm;
  logic [31:0] cur_x, cur_y, cur_z;
  int          vertices;

  polyline_equal_spacing_resampler uut (.*);

  pes_resample_checker checker_i (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tlast_i(m_tlast_o),
    .m_tuser_i(m_tuser_o), .cfg_we_i, .cfg_wdata_i, .err_count_o(err_count),
    .pending_o(pending), .delivered_o(delivered), .overflow_seen_o(overflow_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d points still expected", cycles, pending);
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    bit held;
    held = 0;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && delivered >= 60) begin
        held = 1;
        m_tready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      m_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  task automatic send_vertex(input logic first, input logic [31:0] x, y, z);
    if (!calm && $urandom_range(99) < 16) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= first;
    s_tdata_i  <= {z, y, x};
    do @(posedge clk_i); while (!s_tready_o);
    cur_x = x; cur_y = y; cur_z = z;
    vertices++;
  endtask

  task automatic set_spacing(input logic [30:0] value);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic move_by(input longint dx, dy, dz);
    send_vertex(1'b0, cur_x + 32'(dx), cur_y + 32'(dy), cur_z + 32'(dz));
  endtask

  task automatic random_path(input int n, input logic [30:0] sp);
    longint sc;
    int     pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      sc = longint'(sp) * $urandom_range(1, 3);
      if (pick < 5)
        send_vertex(1'b1, $urandom, $urandom, $urandom);
      else if (pick < 10)
        send_vertex(1'b0, $urandom, $urandom, $urandom);
      else if (pick < 15)
        move_by(0, 0, 0);
      else
        move_by(longint'($urandom_range(0, 32'(2 * sc))) - sc,
                longint'($urandom_range(0, 32'(2 * sc))) - sc,
                longint'($urandom_range(0, 32'(2 * sc))) - sc);
    end
  endtask

  initial begin
    logic [30:0] sp;
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0; s_tuser_i = 1'b0; s_tdata_i = '0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    calm = 1'b0; vertices = 0;
    cur_x = '0; cur_y = '0; cur_z = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset spacing of 100.0; first item lacks the first flag but has no previous
    send_vertex(1'b0, 32'd256000, 32'hFFFF_0000, 32'd12);
    move_by(89600, 0, 0);                 // 350.0 long: three points, 50.0 left
    move_by(0, 0, 0);                     // zero length, no point reached
    move_by(-300, 700, 1000);
    send_vertex(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // far beyond run cap
    send_vertex(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(1'b1, '0, '0, '0);
    move_by(25600 * 5 + 77, 0, 0);         // leftover stays above the next spacing

    // lowered spacing mid-path: points behind the previous vertex
    set_spacing(31'd1);
    move_by(1, 0, 0);
    move_by(0, 0, 0);
    move_by(25600, 0, 0);
    move_by(-1, 1, -1);

    set_spacing(31'h7FFF_FFFF);
    send_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    move_by(1000, 0, 0);

    sp = 31'($urandom_range(64, 4096));
    set_spacing(sp);
    random_path(80, sp);
    sp = 31'($urandom_range(4096, 1 << 20));
    set_spacing(sp);
    calm = 1'b1;
    random_path(80, sp);
    calm = 1'b0;
    sp = 31'($urandom_range(1, 64));
    set_spacing(sp);
    random_path(80, sp);
    sp = 31'($urandom_range(1, 31'h7FFF_FFFF));
    set_spacing(sp);
    random_path(80, sp);

    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d vertices over seven spacings; %0d points checked, %0d overflowed",
             vertices, delivered, overflow_seen);
    if (err_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
